// ----- rtl/core/pft_pkg.sv -----
package pft_pkg;

    // Fixed-point formats of the normal and the scaled cross product.
    localparam int NORMAL_FRAC_BITS = 30;
    localparam int SCALE_BITS       = 30;

    // Widths of the internal datapath.
    localparam int MAG_W      = 66;                  // cross product magnitude
    localparam int LEN_W      = 31;                  // square root of the squared length
    localparam int RAD_W      = 2 * LEN_W;           // squared length
    localparam int SQRT_STEPS = LEN_W;
    localparam int DIV_STEPS  = 31;                  // quotient bits per lane
    localparam int NUM_W      = SCALE_BITS + NORMAL_FRAC_BITS + 1;  // rounded numerator

    // One triangle.
    typedef struct packed {
        logic signed [31:0] p0_x;
        logic signed [31:0] p0_y;
        logic signed [31:0] p0_z;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p1_z;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p2_z;
    } in_t;

    // One plane.
    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_dist;
        logic               plane_valid;
    } out_t;

    // Data that rides alongside the square root and the divider.
    typedef struct packed {
        logic signed [31:0]     p0_x;
        logic signed [31:0]     p0_y;
        logic signed [31:0]     p0_z;
        logic [2:0]             neg;
        logic [SCALE_BITS-1:0]  m0;
        logic [SCALE_BITS-1:0]  m1;
        logic [SCALE_BITS-1:0]  m2;
        logic                   degen;
    } side_t;

endpackage

// ----- rtl/core/pft_sqrt.sv -----
module pft_sqrt import pft_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] in_rad,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [LEN_W-1:0] out_root,
    output side_t            out_side
);

    logic             valid_reg [0:SQRT_STEPS];
    logic [RAD_W-1:0] rad_reg   [0:SQRT_STEPS];
    logic [LEN_W+1:0] rem_reg   [0:SQRT_STEPS];
    logic [LEN_W-1:0] root_reg  [0:SQRT_STEPS];
    side_t            side_reg  [0:SQRT_STEPS];

    // Entry stage: load the radicand with an empty root and remainder.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // One root bit per stage: bring down two radicand bits and try a subtraction.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [LEN_W+3:0] t;
        logic [LEN_W+3:0] trial;
        logic             ge;
        logic [LEN_W+1:0] rem_next;
        logic [LEN_W-1:0] root_next;

        assign t         = {rem_reg[k], rad_reg[k][RAD_W-1 -: 2]};
        assign trial     = {2'b00, root_reg[k], 2'b01};
        assign ge        = (t >= trial);
        assign rem_next  = ge ? (LEN_W+2)'(t - trial) : (LEN_W+2)'(t);
        assign root_next = {root_reg[k][LEN_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1]  <= {rad_reg[k][RAD_W-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS];
    assign out_root  = root_reg[SQRT_STEPS];
    assign out_side  = side_reg[SQRT_STEPS];

endmodule

// ----- rtl/core/pft_div.sv -----
module pft_div import pft_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LEN_W-1:0]           in_len,
    input  side_t                      in_side,
    output logic                       out_valid,
    output logic [2:0][DIV_STEPS-1:0]  out_q,
    output side_t                      out_side
);

    logic                      valid_reg [0:DIV_STEPS];
    logic [LEN_W-1:0]          len_reg   [0:DIV_STEPS];
    logic [2:0][LEN_W-1:0]     rem_reg   [0:DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] bits_reg  [0:DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] q_reg     [0:DIV_STEPS];
    side_t                     side_reg  [0:DIV_STEPS];

    // Rounded numerators: m shifted up to the normal format plus half the divisor.
    logic [2:0][NUM_W-1:0] num;
    logic [2:0][SCALE_BITS-1:0] m;

    assign m = {in_side.m2, in_side.m1, in_side.m0};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = {1'b0, m[i], {NORMAL_FRAC_BITS{1'b0}}}
                   + NUM_W'(in_len >> 1);
        end
    end

    // Entry stage: the upper numerator bits are already below the divisor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg[0]  <= in_len;
            side_reg[0] <= in_side;
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i]  <= LEN_W'(num[i][NUM_W-1:DIV_STEPS]);
                bits_reg[0][i] <= num[i][DIV_STEPS-1:0];
                q_reg[0][i]    <= '0;
            end
        end
    end

    // One quotient bit per stage in each of the three lanes.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [2:0][LEN_W-1:0]     rem_next;
        logic [2:0][DIV_STEPS-1:0] q_next;

        always_comb begin
            logic [LEN_W:0] t;
            logic           ge;
            for (int i = 0; i < 3; i++) begin
                t           = {rem_reg[k][i], bits_reg[k][i][DIV_STEPS-1]};
                ge          = (t >= {1'b0, len_reg[k]});
                rem_next[i] = ge ? LEN_W'(t - {1'b0, len_reg[k]}) : LEN_W'(t);
                q_next[i]   = {q_reg[k][i][DIV_STEPS-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[k+1]  <= len_reg[k];
                side_reg[k+1] <= side_reg[k];
                rem_reg[k+1]  <= rem_next;
                q_reg[k+1]    <= q_next;
                for (int i = 0; i < 3; i++) begin
                    bits_reg[k+1][i] <= {bits_reg[k][i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_q     = q_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

endmodule

// ----- rtl/core/plane_from_triangle_top.sv -----
// Plane through three points. Each transfer on the s_ channel carries one triangle in
// signed Q16.16 and gives one transfer on the m_ channel with the unit normal in Q2.30,
// the distance from the origin in Q16.16 (saturated) and a flag that is low for a
// degenerate triangle, whose normal and distance are then zero. The block takes one
// triangle per cycle unless the output stalls, and results leave in input order after
// edges, cross product, scaling and squared length, the square root pipeline, the
// three-lane divider pipeline and the distance stages. The whole pipeline advances
// together, so a low m_ready while m_valid is high holds every stage and s_ready.
module plane_from_triangle_top import pft_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic en;
    logic m_valid_reg;
    out_t m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Position of the highest set bit plus one, zero for a zero word.
    function automatic logic [6:0] bit_len(input logic [MAG_W-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    // Stage 1: edges.
    logic                     v1_reg;
    logic signed [2:0][32:0]  e1_reg, e2_reg;
    logic signed [2:0][31:0]  p0_1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg[0] <= 33'(s_data.p1_x) - 33'(s_data.p0_x);
            e1_reg[1] <= 33'(s_data.p1_y) - 33'(s_data.p0_y);
            e1_reg[2] <= 33'(s_data.p1_z) - 33'(s_data.p0_z);
            e2_reg[0] <= 33'(s_data.p2_x) - 33'(s_data.p0_x);
            e2_reg[1] <= 33'(s_data.p2_y) - 33'(s_data.p0_y);
            e2_reg[2] <= 33'(s_data.p2_z) - 33'(s_data.p0_z);
            p0_1_reg  <= {s_data.p0_z, s_data.p0_y, s_data.p0_x};
        end
    end

    // Stage 2: the six partial products of e2 x e1.
    logic                    v2_reg;
    logic signed [65:0]      pa_reg [0:2];
    logic signed [65:0]      pb_reg [0:2];
    logic signed [2:0][31:0] p0_2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg[0] <= 66'($signed(e2_reg[1]) * $signed(e1_reg[2]));
            pb_reg[0] <= 66'($signed(e2_reg[2]) * $signed(e1_reg[1]));
            pa_reg[1] <= 66'($signed(e2_reg[2]) * $signed(e1_reg[0]));
            pb_reg[1] <= 66'($signed(e2_reg[0]) * $signed(e1_reg[2]));
            pa_reg[2] <= 66'($signed(e2_reg[0]) * $signed(e1_reg[1]));
            pb_reg[2] <= 66'($signed(e2_reg[1]) * $signed(e1_reg[0]));
            p0_2_reg  <= p0_1_reg;
        end
    end

    // Stage 3: cross product components as sign and magnitude.
    logic                    v3_reg;
    logic [MAG_W-1:0]        mag3_reg [0:2];
    logic [2:0]              neg3_reg;
    logic signed [2:0][31:0] p0_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [66:0] c;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c           = 67'(pa_reg[i]) - 67'(pb_reg[i]);
                neg3_reg[i] <= c[66];
                mag3_reg[i] <= c[66] ? MAG_W'(-c) : MAG_W'(c);
            end
            p0_3_reg <= p0_2_reg;
        end
    end

    // Stage 4: bit length of the largest magnitude.
    logic                    v4_reg;
    logic [MAG_W-1:0]        mag4_reg [0:2];
    logic [2:0]              neg4_reg;
    logic [6:0]              l4_reg;
    logic signed [2:0][31:0] p0_4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            l4_reg   <= bit_len(mag3_reg[0] | mag3_reg[1] | mag3_reg[2]);
            p0_4_reg <= p0_3_reg;
        end
    end

    // Stage 5: common shift so that the largest magnitude has thirty bits.
    logic  v5_reg;
    side_t side5_reg;
    logic [2:0][SCALE_BITS-1:0] m5;

    always_comb begin
        logic [MAG_W-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (l4_reg > 7'(SCALE_BITS)) begin
                sh = mag4_reg[i] >> (l4_reg - 7'(SCALE_BITS));
            end else begin
                sh = mag4_reg[i] << (7'(SCALE_BITS) - l4_reg);
            end
            m5[i] = sh[SCALE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side5_reg.p0_x  <= p0_4_reg[0];
            side5_reg.p0_y  <= p0_4_reg[1];
            side5_reg.p0_z  <= p0_4_reg[2];
            side5_reg.neg   <= neg4_reg;
            side5_reg.m0    <= m5[0];
            side5_reg.m1    <= m5[1];
            side5_reg.m2    <= m5[2];
            side5_reg.degen <= (l4_reg == 7'd0);
        end
    end

    // Stage 6: squares of the scaled components.
    logic  v6_reg;
    side_t side6_reg;
    logic [2*SCALE_BITS-1:0] sq6_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq6_reg[0] <= side5_reg.m0 * side5_reg.m0;
            sq6_reg[1] <= side5_reg.m1 * side5_reg.m1;
            sq6_reg[2] <= side5_reg.m2 * side5_reg.m2;
            side6_reg  <= side5_reg;
        end
    end

    // Stage 7: squared length.
    logic             v7_reg;
    side_t            side7_reg;
    logic [RAD_W-1:0] len2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len2_reg  <= RAD_W'(sq6_reg[0]) + RAD_W'(sq6_reg[1]) + RAD_W'(sq6_reg[2]);
            side7_reg <= side6_reg;
        end
    end

    // Length by square root, then each component divided by it.
    logic             sq_valid;
    logic [LEN_W-1:0] sq_root;
    side_t            sq_side;

    pft_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rad    (len2_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic                      dv_valid;
    logic [2:0][DIV_STEPS-1:0] dv_q;
    side_t                     dv_side;

    pft_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // Stage 8: clamp to one, apply the sign, zero a degenerate triangle.
    logic                    v8_reg;
    logic signed [2:0][31:0] n8_reg;
    logic signed [2:0][31:0] p0_8_reg;
    logic                    degen8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [31:0] q;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                q = 32'(dv_q[i]);
                if (q > (32'd1 << NORMAL_FRAC_BITS)) begin
                    q = 32'd1 << NORMAL_FRAC_BITS;
                end
                if (dv_side.degen) begin
                    n8_reg[i] <= '0;
                end else begin
                    n8_reg[i] <= dv_side.neg[i] ? -$signed(q) : $signed(q);
                end
            end
            p0_8_reg   <= {dv_side.p0_z, dv_side.p0_y, dv_side.p0_x};
            degen8_reg <= dv_side.degen;
        end
    end

    // Stage 9: products of the first vertex with the normal.
    logic                    v9_reg;
    logic signed [63:0]      dp9_reg [0:2];
    logic signed [2:0][31:0] n9_reg;
    logic                    degen9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dp9_reg[i] <= 64'($signed(p0_8_reg[i]) * $signed(n8_reg[i]));
            end
            n9_reg     <= n8_reg;
            degen9_reg <= degen8_reg;
        end
    end

    // Output register: sum, round half up, saturate to 32 bits.
    logic signed [65:0] acc;
    logic signed [35:0] dist_rnd;
    logic signed [31:0] dist_sat;

    always_comb begin
        acc      = 66'(dp9_reg[0]) + 66'(dp9_reg[1]) + 66'(dp9_reg[2])
                 + (66'sd1 <<< (NORMAL_FRAC_BITS - 1));
        dist_rnd = 36'(acc >>> NORMAL_FRAC_BITS);
        if (dist_rnd > 36'sd2147483647) begin
            dist_sat = 32'sh7fffffff;
        end else if (dist_rnd < -36'sd2147483648) begin
            dist_sat = 32'sh80000000;
        end else begin
            dist_sat = 32'(dist_rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.normal_x    <= n9_reg[0];
            m_data_reg.normal_y    <= n9_reg[1];
            m_data_reg.normal_z    <= n9_reg[2];
            m_data_reg.plane_dist  <= dist_sat;
            m_data_reg.plane_valid <= !degen9_reg;
        end
    end

endmodule

// ----- tb/tb_plane_from_triangle_top.sv -----
module tb_plane_from_triangle_top;
    import pft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 74;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    in_t  pending_triangles[$];
    out_t expected_planes[$];
    int   error_count;
    bit   stimulus_done;
    bit   hold_off_req;
    int   send_gap;
    int   recv_gap;
    int   hold_off_left;
    bit   s_accepted;
    bit   m_accepted;

    plane_from_triangle_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock and reset.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Floor square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Plane through the three vertices of a triangle.
    function automatic out_t plane_of(input in_t t);
        logic signed [33:0]  e1 [3];
        logic signed [33:0]  e2 [3];
        logic signed [31:0]  p0 [3];
        logic signed [127:0] cr [3];
        logic [127:0]        mag [3];
        logic [2:0]          neg;
        logic [63:0]         m [3];
        logic [63:0]         len2;
        logic [63:0]         len;
        logic [63:0]         q;
        logic signed [63:0]  n [3];
        logic signed [127:0] acc;
        logic signed [127:0] d;
        int                  top_bit;
        out_t                r;
        p0[0] = t.p0_x; p0[1] = t.p0_y; p0[2] = t.p0_z;
        e1[0] = 34'(t.p1_x) - 34'(t.p0_x);
        e1[1] = 34'(t.p1_y) - 34'(t.p0_y);
        e1[2] = 34'(t.p1_z) - 34'(t.p0_z);
        e2[0] = 34'(t.p2_x) - 34'(t.p0_x);
        e2[1] = 34'(t.p2_y) - 34'(t.p0_y);
        e2[2] = 34'(t.p2_z) - 34'(t.p0_z);
        cr[0] = 128'(e2[1]) * 128'(e1[2]) - 128'(e2[2]) * 128'(e1[1]);
        cr[1] = 128'(e2[2]) * 128'(e1[0]) - 128'(e2[0]) * 128'(e1[2]);
        cr[2] = 128'(e2[0]) * 128'(e1[1]) - 128'(e2[1]) * 128'(e1[0]);
        top_bit = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? -cr[i] : cr[i];
            for (int b = 0; b < 128; b++) begin
                if (mag[i][b] && b + 1 > top_bit) begin
                    top_bit = b + 1;
                end
            end
        end
        r = '0;
        if (top_bit == 0) begin
            return r;
        end
        // Normalise so the largest component has exactly SCALE_BITS bits.
        for (int i = 0; i < 3; i++) begin
            if (top_bit > SCALE_BITS) begin
                m[i] = 64'(mag[i] >> (top_bit - SCALE_BITS));
            end else begin
                m[i] = 64'(mag[i] << (SCALE_BITS - top_bit));
            end
        end
        len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len  = floor_sqrt(len2);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
            if (q > (64'd1 << NORMAL_FRAC_BITS)) begin
                q = 64'd1 << NORMAL_FRAC_BITS;
            end
            n[i] = neg[i] ? -$signed(q) : $signed(q);
        end
        acc = 128'(p0[0]) * 128'(n[0]) + 128'(p0[1]) * 128'(n[1])
            + 128'(p0[2]) * 128'(n[2]) + (128'sd1 <<< (NORMAL_FRAC_BITS - 1));
        d = acc >>> NORMAL_FRAC_BITS;
        if (d > 128'sd2147483647) begin
            d = 128'sd2147483647;
        end
        if (d < -128'sd2147483648) begin
            d = -128'sd2147483648;
        end
        r.normal_x    = n[0][31:0];
        r.normal_y    = n[1][31:0];
        r.normal_z    = n[2][31:0];
        r.plane_dist  = d[31:0];
        r.plane_valid = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return $urandom_range(0, 32'hffff) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t random_triangle();
        in_t t;
        logic [31:0] k;
        for (int i = 0; i < 9; i++) begin
            t[32*i +: 32] = any_coord();
        end
        // Some triangles are degenerate: coincident or collinear vertices.
        case ($urandom_range(0, 9))
            0: begin
                t.p1_x = t.p0_x; t.p1_y = t.p0_y; t.p1_z = t.p0_z;
            end
            1: begin
                k = $urandom_range(0, 255);
                t.p1_x = t.p0_x + k; t.p1_y = t.p0_y + 2 * k; t.p1_z = t.p0_z - k;
                t.p2_x = t.p0_x + 3 * k; t.p2_y = t.p0_y + 6 * k;
                t.p2_z = t.p0_z - 3 * k;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic in_t make_tri(input logic [31:0] a, b, c, d, e, f, g, h, i);
        in_t t;
        t.p0_x = a; t.p0_y = b; t.p0_z = c;
        t.p1_x = d; t.p1_y = e; t.p1_z = f;
        t.p2_x = g; t.p2_y = h; t.p2_z = i;
        return t;
    endfunction

    // Stimulus: directed triangles first, then random ones.
    initial begin
        logic [31:0] mn;
        logic [31:0] mx;
        logic [31:0] one;
        mn  = 32'h8000_0000;
        mx  = 32'h7fff_ffff;
        one = 32'h0001_0000;
        stimulus_done = 1'b0;
        pending_triangles.push_back(make_tri(0, 0, 0, one, 0, 0, 0, one, 0));
        pending_triangles.push_back(make_tri(0, 0, one, 0, one, one, one, 0, one));
        pending_triangles.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_triangles.push_back(make_tri(one, one, one, one, one, one, 5, 6, 7));
        pending_triangles.push_back(make_tri(0, 0, 0, one, one, one, 2*one, 2*one, 2*one));
        pending_triangles.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
        pending_triangles.push_back(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
        pending_triangles.push_back(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
        pending_triangles.push_back(make_tri(mx, mx, mn, mn, mx, mx, mx, mn, mx));
        pending_triangles.push_back(make_tri(mn, mn, mn, mn, mn, mn, mx, mx, mx));
        pending_triangles.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_triangles.push_back(make_tri(mx, 0, 0, mx, 1, 0, mx, 0, 1));
        pending_triangles.push_back(make_tri(mn, 0, 0, mn, 1, 0, mn, 0, 1));
        pending_triangles.push_back(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1));
        pending_triangles.push_back(make_tri(-1, -1, -1, 32'hffff_ffff, 0, mx, mn, 1, 0));
        pending_triangles.push_back(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 10));
        for (int i = 0; i < 700; i++) begin
            pending_triangles.push_back(random_triangle());
        end
        stimulus_done = 1'b1;
    end

    // Transfers seen at each rising edge, for the processes that act on the falling edge.
    always @(posedge aclk) begin
        s_accepted <= s_valid && s_ready;
        m_accepted <= m_valid && m_ready;
    end

    // Driver: offers one triangle per transfer, with a random gap before each.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= $urandom_range(0, 4);
        end else if (s_valid && !s_accepted) begin
            // Hold the offer until it is taken.
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_triangles.size() > 0) begin
            s_valid  <= 1'b1;
            s_data   <= pending_triangles.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // A long receiver hold-off once the pipeline has taken some triangles.
    initial begin
        hold_off_req = 1'b0;
        wait (stimulus_done && pending_triangles.size() < 600);
        hold_off_req = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off_req = 1'b0;
    end

    // Receiver: ready goes low for a random number of cycles per transfer.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else if (hold_off_req) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            m_ready  <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (m_accepted) begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_planes.push_back(plane_of(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_planes.size() == 0) begin
                    $error("plane transfer with no triangle outstanding");
                    error_count++;
                end else begin
                    want = expected_planes.pop_front();
                    if (m_data.normal_x !== want.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", want.normal_x,
                               m_data.normal_x);
                        error_count++;
                    end
                    if (m_data.normal_y !== want.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", want.normal_y,
                               m_data.normal_y);
                        error_count++;
                    end
                    if (m_data.normal_z !== want.normal_z) begin
                        $error("normal_z: expected %0d, got %0d", want.normal_z,
                               m_data.normal_z);
                        error_count++;
                    end
                    if (m_data.plane_dist !== want.plane_dist) begin
                        $error("plane_dist: expected %0d, got %0d", want.plane_dist,
                               m_data.plane_dist);
                        error_count++;
                    end
                    if (m_data.plane_valid !== want.plane_valid) begin
                        $error("plane_valid: expected %0b, got %0b", want.plane_valid,
                               m_data.plane_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // End of run: drain, then allow the pipeline latency for any stray output.
    initial begin
        error_count = 0;
        wait (aresetn);
        wait (stimulus_done && pending_triangles.size() == 0);
        @(posedge aclk);
        wait (!s_valid && expected_planes.size() == 0);
        repeat (2 * LATENCY) @(posedge aclk);
        if (expected_planes.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pft_pkg.sv
rtl/core/pft_sqrt.sv
rtl/core/pft_div.sv
rtl/core/plane_from_triangle_top.sv
tb/tb_plane_from_triangle_top.sv
